// ----- rtl/cubic_antipodal_julia_escape_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the cubic antipodal Julia escape block
// Immediate-implication and next-cycle-implication checks on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef CUBIC_ANTIPODAL_JULIA_ESCAPE_ASSERT_SVH
`define CUBIC_ANTIPODAL_JULIA_ESCAPE_ASSERT_SVH

// check cons in the same cycle as ante
`define CAJE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// check cons in the cycle after ante
`define CAJE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/caje_pkg.sv -----
// ----------------------------------------------------------------------------
// caje_pkg
// Types, codes and fixed-point helpers shared by the escape-time block.
// ----------------------------------------------------------------------------
package caje_pkg;

  localparam int CW        = 32;
  localparam int FRAC      = 24;
  localparam int BIG_SHIFT = 3 * FRAC - 32;
  localparam int ACC_W     = 48;
  localparam int DIV_STEPS = 2 * FRAC;
  localparam int CFG_AW    = 3;

  localparam logic signed [CW-1:0]    CMAX = 32'sh7FFF_FFFF;
  localparam logic signed [CW-1:0]    CMIN = 32'sh8000_0000;
  localparam logic signed [ACC_W-1:0] SAT_HI = 48'sh0000_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] SAT_LO = -48'sh0000_8000_0000;
  localparam logic signed [ACC_W-1:0] ONE_W  = 48'sd1 <<< FRAC;

  localparam logic [CFG_AW-1:0] CFG_C_RE  = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_C_IM  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_MAXIT = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_MAXP  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_EPS   = 3'd4;

  typedef enum logic [1:0] {OC_ZERO, OC_INF, OC_CYCLE, OC_UNDEC} outcome_t;

  typedef struct packed {
    logic signed [CW-1:0] point_re;
    logic signed [CW-1:0] point_im;
  } in_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [15:0] iterations;
    logic        side;
    logic [3:0]  cycle_index;
  } out_t;

  typedef enum logic [5:0] {
    S_IDLE, S_LIM, S_N0, S_N1, S_N2, S_N3, S_N4, S_N5, S_DEC,
    S_A0, S_A1, S_A2, S_A3, S_A4, S_A5, S_A6, S_A7, S_A8, S_A9, S_A10,
    S_DEAD, S_DSR, S_DSTR, S_DWR, S_DSI, S_DSTI, S_DWI,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8,
    S_F0, S_F1, S_F2, S_SR0, S_SR1, S_SR2, S_SR3, S_SR4, S_SR5, S_RES
  } state_t;

  typedef enum logic [5:0] {
    OP_NOP, OP_LOAD, OP_N0, OP_N1, OP_N2, OP_N3, OP_N4, OP_N5,
    OP_A0, OP_A1, OP_A2, OP_A3, OP_A4, OP_A5, OP_A6, OP_A7, OP_A8, OP_A9, OP_A10,
    OP_DEAD, OP_DSR, OP_DSI, OP_DSTEP, OP_DWR, OP_DWI,
    OP_M0, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6, OP_M7, OP_M8,
    OP_F0, OP_F1, OP_F2, OP_SDIF, OP_SM0, OP_SM1, OP_SCMP, OP_RES
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic lt_mi;
    logic brk;
    logic q_zero;
    logic div_done;
    logic more;
    logic found;
  } stat_t;

  function automatic logic signed [CW-1:0] sat(input logic signed [ACC_W-1:0] v);
    logic signed [CW-1:0] r;
    if (v > SAT_HI) r = CMAX;
    else if (v < SAT_LO) r = CMIN;
    else r = v[CW-1:0];
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] flr(input logic signed [2*CW+1:0] p);
    logic signed [2*CW+1:0] s;
    s = p >>> FRAC;
    return s[ACC_W-1:0];
  endfunction

endpackage

// ----- rtl/caje_ram.sv -----
// ----------------------------------------------------------------------------
// caje_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module caje_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/caje_ctrl.sv -----
// ----------------------------------------------------------------------------
// caje_ctrl
// Sequencer: steps the datapath through check, map, divide and classify.
// ----------------------------------------------------------------------------
`include "cubic_antipodal_julia_escape_assert.svh"

module caje_ctrl import caje_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   res_load;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign res_load  = (state_r == S_RES) && !(out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    if (res_load) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_LIM;
      S_LIM:  state_nxt = stat.lt_mi ? S_N0 : S_SR0;
      S_N0:   state_nxt = S_N1;
      S_N1:   state_nxt = S_N2;
      S_N2:   state_nxt = S_N3;
      S_N3:   state_nxt = S_N4;
      S_N4:   state_nxt = S_N5;
      S_N5:   state_nxt = S_DEC;
      S_DEC:  state_nxt = stat.brk ? S_F0 : S_A0;
      S_A0:   state_nxt = S_A1;
      S_A1:   state_nxt = S_A2;
      S_A2:   state_nxt = S_A3;
      S_A3:   state_nxt = S_A4;
      S_A4:   state_nxt = S_A5;
      S_A5:   state_nxt = S_A6;
      S_A6:   state_nxt = S_A7;
      S_A7:   state_nxt = S_A8;
      S_A8:   state_nxt = S_A9;
      S_A9:   state_nxt = S_A10;
      S_A10:  state_nxt = stat.q_zero ? S_DEAD : S_DSR;
      S_DEAD: state_nxt = S_F0;
      S_DSR:  state_nxt = S_DSTR;
      S_DSTR: if (stat.div_done) state_nxt = S_DWR;
      S_DWR:  state_nxt = S_DSI;
      S_DSI:  state_nxt = S_DSTI;
      S_DSTI: if (stat.div_done) state_nxt = S_DWI;
      S_DWI:  state_nxt = S_M0;
      S_M0:   state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_M3;
      S_M3:   state_nxt = S_M4;
      S_M4:   state_nxt = S_M5;
      S_M5:   state_nxt = S_M6;
      S_M6:   state_nxt = S_M7;
      S_M7:   state_nxt = S_M8;
      S_M8:   state_nxt = S_LIM;
      S_F0:   state_nxt = S_F1;
      S_F1:   state_nxt = S_F2;
      S_F2:   state_nxt = S_RES;
      S_SR0:  state_nxt = stat.more ? S_SR1 : S_RES;
      S_SR1:  state_nxt = S_SR2;
      S_SR2:  state_nxt = S_SR3;
      S_SR3:  state_nxt = S_SR4;
      S_SR4:  state_nxt = S_SR5;
      S_SR5:  state_nxt = stat.found ? S_RES : S_SR0;
      S_RES:  if (res_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NOP;
    case (state_r)
      S_IDLE: if (in_valid) cmd.op = OP_LOAD;
      S_N0:   cmd.op = OP_N0;
      S_N1:   cmd.op = OP_N1;
      S_N2:   cmd.op = OP_N2;
      S_N3:   cmd.op = OP_N3;
      S_N4:   cmd.op = OP_N4;
      S_N5:   cmd.op = OP_N5;
      S_A0:   cmd.op = OP_A0;
      S_A1:   cmd.op = OP_A1;
      S_A2:   cmd.op = OP_A2;
      S_A3:   cmd.op = OP_A3;
      S_A4:   cmd.op = OP_A4;
      S_A5:   cmd.op = OP_A5;
      S_A6:   cmd.op = OP_A6;
      S_A7:   cmd.op = OP_A7;
      S_A8:   cmd.op = OP_A8;
      S_A9:   cmd.op = OP_A9;
      S_A10:  cmd.op = OP_A10;
      S_DEAD: cmd.op = OP_DEAD;
      S_DSR:  cmd.op = OP_DSR;
      S_DSTR: cmd.op = OP_DSTEP;
      S_DWR:  cmd.op = OP_DWR;
      S_DSI:  cmd.op = OP_DSI;
      S_DSTI: cmd.op = OP_DSTEP;
      S_DWI:  cmd.op = OP_DWI;
      S_M0:   cmd.op = OP_M0;
      S_M1:   cmd.op = OP_M1;
      S_M2:   cmd.op = OP_M2;
      S_M3:   cmd.op = OP_M3;
      S_M4:   cmd.op = OP_M4;
      S_M5:   cmd.op = OP_M5;
      S_M6:   cmd.op = OP_M6;
      S_M7:   cmd.op = OP_M7;
      S_M8:   cmd.op = OP_M8;
      S_F0:   cmd.op = OP_F0;
      S_F1:   cmd.op = OP_F1;
      S_F2:   cmd.op = OP_F2;
      S_SR1:  cmd.op = OP_SDIF;
      S_SR2:  cmd.op = OP_SM0;
      S_SR3:  cmd.op = OP_SM1;
      S_SR4:  cmd.op = OP_SCMP;
      S_RES:  if (res_load) cmd.op = OP_RES;
      default: cmd.op = OP_NOP;
    endcase
  end

  `CAJE_ASSERT_NEXT(a_load_seq, in_valid && !in_stall, state_r == S_LIM)
  `CAJE_ASSERT_NEXT(a_div_exit, state_r == S_DSTR && stat.div_done, state_r == S_DWR)
  `CAJE_ASSERT_NEXT(a_res_hold, state_r == S_RES && out_valid_r && out_stall, state_r == S_RES && out_valid_r)
  `CAJE_ASSERT_NEXT(a_res_load, res_load, out_valid_r && state_r == S_IDLE)

endmodule

// ----- rtl/caje_dp.sv -----
// ----------------------------------------------------------------------------
// caje_dp
// Datapath: config registers, shared 33x33 multiplier, bit-serial divider,
// orbit store access and result register.
// ----------------------------------------------------------------------------
module caje_dp import caje_pkg::*; #(
  parameter int MAX_PERIOD = 16,
  localparam int AW = $clog2(MAX_PERIOD)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  in_t               in_word,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [31:0]       cfg_wdata,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [2*CW-1:0]   ram_wdata,
  output logic [AW-1:0]     ram_raddr,
  input  logic [2*CW-1:0]   ram_rdata,
  output stat_t             stat,
  output out_t              out_word
);

  localparam logic [16:0] MP_CAP = 17'(MAX_PERIOD);
  localparam logic [47:0] QMAX_P = 48'h0000_7FFF_FFFF;
  localparam logic [47:0] QMAX_N = 48'h0000_8000_0000;

  logic signed [CW-1:0] c_re_r, c_im_r;
  logic [15:0]          mi_r;
  logic [4:0]           mp_r;
  logic [31:0]          eps_r;

  logic signed [CW-1:0] xr_r, xi_r, dr_r, di_r, er_r, ei_r, rr_r, ri_r, tr_r, ti_r;
  logic signed [ACC_W-1:0] acc_r, pr_r, pi_r;
  logic signed [2*CW+1:0]  p_r;
  logic [63:0]          n_r, q_r, blo_r;
  logic signed [2*CW+2:0]  sacc_r;
  logic                 small_r, big_r, dead_r, found_r, side_r;
  logic [15:0]          cnt_r, j_r;
  logic [3:0]           cidx_r;
  logic [63:0]          rem_r;
  logic [47:0]          quo_r;
  logic                 dneg_r, dsat_r;
  logic [5:0]           dcnt_r;
  out_t                 out_r;

  logic signed [CW:0]      ma, mb;
  logic signed [2*CW+1:0]  prod;
  logic signed [ACC_W-1:0] flp;
  logic [63:0]          epsq;
  logic [64:0]          tbig;
  logic                 big_c, small_c, inf_c;
  logic [16:0]          mp_eff;
  logic [15:0]          kidx;
  logic                 store_c;
  logic signed [CW-1:0] o_re, o_im;
  logic [63:0]          dnorm;
  logic [64:0]          rem2;
  logic                 ge;
  logic signed [ACC_W-1:0] dsrc;
  logic [47:0]          dmag;
  logic signed [CW-1:0] divres;
  logic signed [2*CW+2:0]  sres;
  outcome_t             oc;

  assign prod    = ma * mb;
  assign flp     = flr(p_r);
  assign epsq    = {8'd0, eps_r, 24'd0};
  assign tbig    = {1'b0, p_r[63:0]} + {33'd0, blo_r[63:32]};
  assign big_c   = |tbig[64:BIG_SHIFT];
  assign small_c = (n_r <= epsq);
  assign inf_c   = dead_r || !small_r;
  assign mp_eff  = ({12'd0, mp_r} > MP_CAP) ? MP_CAP : {12'd0, mp_r};
  assign kidx    = mi_r - 16'd1 - cnt_r;
  assign store_c = (({1'b0, cnt_r} + mp_eff) >= {1'b0, mi_r}) && ({1'b0, kidx} < MP_CAP);

  assign ram_we    = (cmd.op == OP_N5) && !(small_c || big_c) && store_c;
  assign ram_waddr = kidx[AW-1:0];
  assign ram_wdata = {xr_r, xi_r};
  assign ram_raddr = j_r[AW-1:0];
  assign o_re      = ram_rdata[2*CW-1:CW];
  assign o_im      = ram_rdata[CW-1:0];
  assign dnorm     = q_r + p_r[63:0];

  assign rem2 = {rem_r, 1'b0};
  assign ge   = (rem2 >= {1'b0, q_r});
  assign dsrc = (cmd.op == OP_DSR) ? pr_r : pi_r;
  assign dmag = dsrc[ACC_W-1] ? 48'(-dsrc) : 48'(dsrc);
  assign sres = inf_c ? (sacc_r + 67'(p_r)) : (sacc_r - 67'(p_r));

  always_comb begin
    if (dsat_r) divres = dneg_r ? CMIN : CMAX;
    else if (dneg_r) divres = (quo_r > QMAX_N) ? CMIN : -quo_r[CW-1:0];
    else divres = (quo_r > QMAX_P) ? CMAX : quo_r[CW-1:0];
  end

  always_comb begin
    if (dead_r) oc = OC_INF;
    else if (cnt_r < mi_r) oc = small_r ? OC_ZERO : OC_INF;
    else oc = found_r ? OC_CYCLE : OC_UNDEC;
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_N0: begin ma = {xr_r[CW-1], xr_r}; mb = {xr_r[CW-1], xr_r}; end
      OP_N1: begin ma = {xi_r[CW-1], xi_r}; mb = {xi_r[CW-1], xi_r}; end
      OP_N3: begin ma = {1'b0, n_r[31:0]};  mb = {1'b0, eps_r}; end
      OP_N4: begin ma = {1'b0, n_r[63:32]}; mb = {1'b0, eps_r}; end
      OP_A0: begin ma = {c_re_r[CW-1], c_re_r}; mb = {xr_r[CW-1], xr_r}; end
      OP_A1: begin ma = {c_im_r[CW-1], c_im_r}; mb = {xi_r[CW-1], xi_r}; end
      OP_A2: begin ma = {c_re_r[CW-1], c_re_r}; mb = {xi_r[CW-1], xi_r}; end
      OP_A3: begin ma = {c_im_r[CW-1], c_im_r}; mb = {xr_r[CW-1], xr_r}; end
      OP_A4: begin ma = {er_r[CW-1], er_r}; mb = {er_r[CW-1], er_r}; end
      OP_A5: begin ma = {ei_r[CW-1], ei_r}; mb = {ei_r[CW-1], ei_r}; end
      OP_A6: begin ma = {dr_r[CW-1], dr_r}; mb = {er_r[CW-1], er_r}; end
      OP_A7: begin ma = {di_r[CW-1], di_r}; mb = {ei_r[CW-1], ei_r}; end
      OP_A8: begin ma = {di_r[CW-1], di_r}; mb = {er_r[CW-1], er_r}; end
      OP_A9: begin ma = {dr_r[CW-1], dr_r}; mb = {ei_r[CW-1], ei_r}; end
      OP_M0: begin ma = {xr_r[CW-1], xr_r}; mb = {rr_r[CW-1], rr_r}; end
      OP_M1: begin ma = {xi_r[CW-1], xi_r}; mb = {ri_r[CW-1], ri_r}; end
      OP_M2: begin ma = {xr_r[CW-1], xr_r}; mb = {ri_r[CW-1], ri_r}; end
      OP_M3: begin ma = {xi_r[CW-1], xi_r}; mb = {rr_r[CW-1], rr_r}; end
      OP_M4: begin ma = {xr_r[CW-1], xr_r}; mb = {tr_r[CW-1], tr_r}; end
      OP_M5: begin ma = {xi_r[CW-1], xi_r}; mb = {ti_r[CW-1], ti_r}; end
      OP_M6: begin ma = {xr_r[CW-1], xr_r}; mb = {ti_r[CW-1], ti_r}; end
      OP_M7: begin ma = {xi_r[CW-1], xi_r}; mb = {tr_r[CW-1], tr_r}; end
      OP_F0: begin
        if (inf_c) begin
          ma = {c_re_r[CW-1], c_re_r}; mb = {xi_r[CW-1], xi_r};
        end else begin
          ma = {xr_r[CW-1], xr_r}; mb = {c_im_r[CW-1], c_im_r};
        end
      end
      OP_F1: begin
        if (inf_c) begin
          ma = {c_im_r[CW-1], c_im_r}; mb = {xr_r[CW-1], xr_r};
        end else begin
          ma = {xi_r[CW-1], xi_r}; mb = {c_re_r[CW-1], c_re_r};
        end
      end
      OP_SM0: begin ma = {dr_r[CW-1], dr_r}; mb = {dr_r[CW-1], dr_r}; end
      OP_SM1: begin ma = {di_r[CW-1], di_r}; mb = {di_r[CW-1], di_r}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_re_r  <= '0;
      c_im_r  <= ONE_W[CW-1:0];
      mi_r    <= 16'd100;
      mp_r    <= 5'd10;
      eps_r   <= 32'd1678;
      small_r <= 1'b0;
      big_r   <= 1'b0;
      dead_r  <= 1'b0;
      found_r <= 1'b0;
      dcnt_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_C_RE:  c_re_r <= cfg_wdata;
          CFG_C_IM:  c_im_r <= cfg_wdata;
          CFG_MAXIT: mi_r   <= cfg_wdata[15:0];
          CFG_MAXP:  mp_r   <= cfg_wdata[4:0];
          CFG_EPS:   eps_r  <= cfg_wdata;
          default: ;
        endcase
      end
      case (cmd.op)
        OP_LOAD: begin
          small_r <= 1'b0;
          big_r   <= 1'b0;
          dead_r  <= 1'b0;
          found_r <= 1'b0;
        end
        OP_N5: begin
          small_r <= small_c;
          big_r   <= big_c;
        end
        OP_DEAD: dead_r <= 1'b1;
        OP_DSR, OP_DSI: dcnt_r <= ({16'd0, dmag} >= q_r) ? 6'd0 : 6'(DIV_STEPS);
        OP_DSTEP: if (dcnt_r != 6'd0) dcnt_r <= dcnt_r - 6'd1;
        OP_SCMP: if (dnorm < epsq) found_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p_r <= prod;
    case (cmd.op)
      OP_LOAD: begin
        xr_r   <= in_word.point_re;
        xi_r   <= in_word.point_im;
        cnt_r  <= '0;
        j_r    <= '0;
        side_r <= 1'b0;
        cidx_r <= '0;
      end
      OP_N1: n_r   <= p_r[63:0];
      OP_N2: n_r   <= n_r + p_r[63:0];
      OP_N4: blo_r <= p_r[63:0];
      OP_A0: begin
        dr_r <= sat(48'(xr_r) - 48'(c_re_r));
        di_r <= sat(48'(xi_r) - 48'(c_im_r));
      end
      OP_A1:  acc_r <= ONE_W + flp;
      OP_A2:  er_r  <= sat(acc_r + flp);
      OP_A3:  acc_r <= flp;
      OP_A4:  ei_r  <= sat(acc_r - flp);
      OP_A5:  q_r   <= p_r[63:0];
      OP_A6:  q_r   <= q_r + p_r[63:0];
      OP_A7:  acc_r <= flp;
      OP_A8:  pr_r  <= acc_r + flp;
      OP_A9:  acc_r <= flp;
      OP_A10: pi_r  <= acc_r - flp;
      OP_DEAD: cnt_r <= cnt_r + 16'd1;
      OP_DSR, OP_DSI: begin
        dneg_r <= dsrc[ACC_W-1];
        dsat_r <= ({16'd0, dmag} >= q_r);
        rem_r  <= {16'd0, dmag};
        quo_r  <= '0;
      end
      OP_DSTEP: begin
        if (dcnt_r != 6'd0) begin
          rem_r <= ge ? 64'(rem2 - {1'b0, q_r}) : rem2[63:0];
          quo_r <= {quo_r[46:0], ge};
        end
      end
      OP_DWR: rr_r  <= divres;
      OP_DWI: ri_r  <= divres;
      OP_M1:  acc_r <= flp;
      OP_M2:  tr_r  <= sat(acc_r - flp);
      OP_M3:  acc_r <= flp;
      OP_M4:  ti_r  <= sat(acc_r + flp);
      OP_M5:  acc_r <= flp;
      OP_M6:  rr_r  <= sat(acc_r - flp);
      OP_M7:  acc_r <= flp;
      OP_M8: begin
        xi_r  <= sat(acc_r + flp);
        xr_r  <= rr_r;
        cnt_r <= cnt_r + 16'd1;
      end
      OP_F1: sacc_r <= 67'(p_r);
      OP_F2: side_r <= !sres[2*CW+2] && (sres != '0);
      OP_SDIF: begin
        dr_r <= sat(48'(xr_r) - 48'(o_re));
        di_r <= sat(48'(xi_r) - 48'(o_im));
      end
      OP_SM1: q_r <= p_r[63:0];
      OP_SCMP: begin
        if (dnorm < epsq) cidx_r <= j_r[3:0];
        else j_r <= j_r + 16'd1;
      end
      OP_RES: begin
        out_r.outcome     <= oc;
        out_r.iterations  <= cnt_r;
        out_r.side        <= side_r;
        out_r.cycle_index <= cidx_r;
      end
      default: ;
    endcase
  end

  assign stat.lt_mi    = (cnt_r < mi_r);
  assign stat.brk      = small_r || big_r;
  assign stat.q_zero   = (q_r == 64'd0);
  assign stat.div_done = (dcnt_r == 6'd0);
  assign stat.more     = (({1'b0, j_r} + 17'd1) < mp_eff) && (j_r < mi_r)
                         && ({1'b0, j_r} < MP_CAP);
  assign stat.found    = found_r;
  assign out_word      = out_r;

endmodule

// ----- rtl/cubic_antipodal_julia_escape.sv -----
// ----------------------------------------------------------------------------
// cubic_antipodal_julia_escape
// Escape-time classifier for x -> x^2 (x - a) / (1 + conj(a) x) in Q8.24.
//
//   channel  ports                          word
//   input    in_valid / in_stall / in_word  start point (re, im)
//   result   out_valid / out_stall / out_word  outcome, count, side, index
//   config   cfg_we / cfg_addr / cfg_wdata  c_re, c_im, max_it, max_per, eps
//
// After acceptance each map step checks the norm, forms the denominator and
// the two quotients and multiplies back; then the side is found on an escape
// or a zero denominator, or the stored orbit entries are compared at the limit.
// Each map step runs 22 products on one shared 33x33 multiplier and two
// 48-step bit-serial quotients, whose steps are skipped when a quotient saturates.
// One point in flight; in_stall is high from acceptance until the result
// is placed in the output register, which holds while out_stall is high.
// Reset is synchronous; orbit store needs no clearing.
// ----------------------------------------------------------------------------
module cubic_antipodal_julia_escape import caje_pkg::*; #(
  parameter int MAX_PERIOD = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_word,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [31:0]       cfg_wdata
);

  localparam int AW = $clog2(MAX_PERIOD);

  cmd_t            cmd;
  stat_t           stat;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [2*CW-1:0] ram_wdata, ram_rdata;

  caje_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  caje_dp #(.MAX_PERIOD(MAX_PERIOD)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_word),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .stat     (stat),
    .out_word (out_word)
  );

  caje_ram #(.WIDTH(2*CW), .DEPTH(MAX_PERIOD)) u_orbit (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

// ----- dv/cubic_antipodal_julia_escape_tb.sv -----
// ----------------------------------------------------------------------------
// Escape-time classifier testbench
// Drives start points through the valid/stall input channel under several
// map parameter, iteration, period and threshold settings, predicts each
// outcome word with a bit-exact fixed-point model of the cubic map or takes a
// pinned expected word, and compares every result word field by field in order of arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cubic_antipodal_julia_escape_tb;
  import caje_pkg::*;

  localparam longint ONE_Q = 64'sd1 << FRAC;
  localparam longint C_HI = 64'sd2147483647;
  localparam longint C_LO = -64'sd2147483648;
  localparam int ORBIT_DEPTH = 16;

  typedef struct {
    longint re;
    longint im;
  } cplx_t;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    bit pinned;
    out_t want;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t in_word;
  logic out_valid;
  logic out_stall;
  out_t out_word;
  logic cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [31:0] cfg_wdata;

  longint par_re, par_im;
  int unsigned iter_lim, period_cfg;
  logic [31:0] eps_cfg;
  cplx_t orbit[ORBIT_DEPTH];

  out_t outcome_q[$];
  int errors;
  bit pin_on;
  out_t pin_val;
  bit stall_quiet;

  cubic_antipodal_julia_escape u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint clamp(longint v);
    return v > C_HI ? C_HI : (v < C_LO ? C_LO : v);
  endfunction

  function automatic longint fl(longint v);
    return v >>> FRAC;
  endfunction

  function automatic logic [63:0] mag2(cplx_t v);
    return 64'(v.re * v.re) + 64'(v.im * v.im);
  endfunction

  function automatic cplx_t cx_mul(cplx_t a, cplx_t b);
    cplx_t r;
    r.re = clamp(fl(a.re * b.re) - fl(a.im * b.im));
    r.im = clamp(fl(a.re * b.im) + fl(a.im * b.re));
    return r;
  endfunction

  function automatic longint quot(longint p, logic [63:0] q);
    bit neg;
    logic [63:0] m, r, quo;
    bit top;
    neg = p < 0;
    m = neg ? 64'(-p) : 64'(p);
    quo = '0;
    if (m >= q) return neg ? C_LO : C_HI;
    r = m;
    for (int k = 0; k < 2 * FRAC; k++) begin
      top = r[63];
      r = r << 1;
      quo = quo << 1;
      if (top || r >= q) begin
        r = r - q;
        quo[0] = 1'b1;
      end
    end
    if (neg) begin
      if (quo > 64'h8000_0000) return C_LO;
      return -longint'(quo);
    end
    return quo > 64'h7FFF_FFFF ? C_HI : longint'(quo);
  endfunction

  function automatic bit map_step(ref cplx_t x);
    cplx_t d, den, r, t;
    logic [63:0] q;
    d.re = clamp(x.re - par_re);
    d.im = clamp(x.im - par_im);
    den.re = clamp(ONE_Q + fl(par_re * x.re) + fl(par_im * x.im));
    den.im = clamp(fl(par_re * x.im) - fl(par_im * x.re));
    q = mag2(den);
    if (q == 0) return 1'b0;
    r.re = quot(fl(d.re * den.re) + fl(d.im * den.im), q);
    r.im = quot(fl(d.im * den.re) - fl(d.re * den.im), q);
    t = cx_mul(x, r);
    x = cx_mul(x, t);
    return 1'b1;
  endfunction

  function automatic bit too_big(logic [63:0] n);
    logic [95:0] p;
    p = 96'(n) * 96'(eps_cfg);
    return |p[95:72];
  endfunction

  function automatic bit side_far(cplx_t x);
    return par_re * x.im > -(par_im * x.re);
  endfunction

  function automatic bit side_near(cplx_t x);
    return x.re * par_im > x.im * par_re;
  endfunction

  function automatic out_t classify(in_t w);
    out_t o;
    cplx_t x, df;
    int unsigned cnt, mp, k;
    logic [63:0] epsq, n;
    bit dead;
    mp = period_cfg > ORBIT_DEPTH ? ORBIT_DEPTH : period_cfg;
    epsq = 64'(eps_cfg) << FRAC;
    x.re = longint'(w.point_re);
    x.im = longint'(w.point_im);
    cnt = 0;
    dead = 1'b0;
    o = '0;
    o.outcome = OC_UNDEC;
    while (cnt < iter_lim) begin
      n = mag2(x);
      if (n <= epsq || too_big(n)) break;
      if (cnt + mp >= iter_lim) begin
        k = iter_lim - 1 - cnt;
        if (k < ORBIT_DEPTH) orbit[k] = x;
      end
      dead = !map_step(x);
      cnt++;
      if (dead) break;
    end
    o.iterations = cnt[15:0];
    if (dead) begin
      o.outcome = OC_INF;
      o.side = side_far(x);
    end else if (cnt < iter_lim) begin
      if (mag2(x) <= epsq) begin
        o.outcome = OC_ZERO;
        o.side = side_near(x);
      end else begin
        o.outcome = OC_INF;
        o.side = side_far(x);
      end
    end else begin
      for (int j = 0; j + 1 < mp && j < iter_lim && j < ORBIT_DEPTH; j++) begin
        df.re = clamp(x.re - orbit[j].re);
        df.im = clamp(x.im - orbit[j].im);
        if (mag2(df) < epsq) begin
          o.outcome = OC_CYCLE;
          o.cycle_index = j[3:0];
          break;
        end
      end
    end
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_t e;
    if (rst_n) begin
      if (in_valid && !in_stall) outcome_q.push_back(pin_on ? pin_val : classify(in_word));
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          report("unexpected word", 32'(out_word), 32'd0);
        end else begin
          e = outcome_q.pop_front();
          if (out_word.outcome !== e.outcome)
            report("outcome", 32'(out_word.outcome), 32'(e.outcome));
          if (out_word.iterations !== e.iterations)
            report("iterations", 32'(out_word.iterations), 32'(e.iterations));
          if (out_word.side !== e.side)
            report("side", 32'(out_word.side), 32'(e.side));
          if (out_word.cycle_index !== e.cycle_index)
            report("cycle_index", 32'(out_word.cycle_index), 32'(e.cycle_index));
        end
      end
    end
  end

  int stall_left;
  always @(negedge clk) begin
    if (stall_quiet) begin
      out_stall = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      out_stall = ($urandom_range(0, 2) == 0);
      stall_left = out_stall ? $urandom_range(0, 12) : $urandom_range(0, 30);
    end
  end

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_C_RE: par_re = longint'(signed'(v));
      CFG_C_IM: par_im = longint'(signed'(v));
      CFG_MAXIT: iter_lim = 32'(v[15:0]);
      CFG_MAXP: period_cfg = 32'(v[4:0]);
      CFG_EPS: eps_cfg = v;
      default: ;
    endcase
  endtask

  task automatic set_all(logic [31:0] a_re, logic [31:0] a_im, logic [15:0] mi,
                         logic [4:0] mp, logic [31:0] e);
    write_reg(CFG_C_RE, a_re);
    write_reg(CFG_C_IM, a_im);
    write_reg(CFG_MAXIT, 32'(mi));
    write_reg(CFG_MAXP, 32'(mp));
    write_reg(CFG_EPS, e);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (outcome_q.size() != 0 && guard < 20_000_000) begin
      @(posedge clk);
      guard++;
    end
    if (outcome_q.size() != 0) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      repeat (20) @(posedge clk);
    end
  endtask

  task automatic send(logic [31:0] re, logic [31:0] im);
    in_word.point_re = re;
    in_word.point_im = im;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'($urandom_range(0, 1) ? 64'sh7FFF_FFFF : -64'sh8000_0000);
      default: return 32'(longint'($urandom_range(0, 5 * ONE_Q)) - 5 * ONE_Q / 2);
    endcase
  endfunction

  function automatic out_t mk(outcome_t oc, int it, bit sd);
    out_t o;
    o = '0;
    o.outcome = oc;
    o.iterations = it[15:0];
    o.side = sd;
    return o;
  endfunction

  row_t rows[$];
  int burst;

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    pin_on = 1'b0;
    pin_val = '0;
    stall_quiet = 1'b0;
    stall_left = 0;
    errors = 0;
    par_re = 0;
    par_im = ONE_Q;
    iter_lim = 100;
    period_cfg = 10;
    eps_cfg = 1678;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: a = i
    rows.push_back('{32'h0, 32'h0, 1'b1, mk(OC_ZERO, 0, 1'b0)});
    rows.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, mk(OC_INF, 0, 1'b1)});
    rows.push_back('{32'h8000_0000, 32'h8000_0000, 1'b1, mk(OC_INF, 0, 1'b0)});
    rows.push_back('{32'h0, 32'(-ONE_Q), 1'b1, mk(OC_INF, 1, 1'b0)});
    rows.push_back('{32'(ONE_Q / 2), 32'(ONE_Q / 3), 1'b0, '0});
    rows.push_back('{32'(ONE_Q), 32'h0, 1'b0, '0});
    rows.push_back('{32'(-ONE_Q), 32'(ONE_Q / 4), 1'b0, '0});
    rows.push_back('{32'(3 * ONE_Q), 32'(-ONE_Q), 1'b0, '0});
    foreach (rows[i]) begin
      pin_on = rows[i].pinned;
      pin_val = rows[i].want;
      send(rows[i].re, rows[i].im);
    end
    drain();
    pin_on = 1'b0;

    // |x|^2 equal to eps, and a fixed point on the unit circle
    set_all(32'h0, 32'h0, 16'd12, 5'd4, 32'(ONE_Q));
    pin_on = 1'b1;
    pin_val = mk(OC_ZERO, 0, 1'b0);
    send(32'(ONE_Q), 32'h0);
    pin_on = 1'b0;
    drain();
    write_reg(CFG_EPS, 32'd1678);
    send(32'(ONE_Q), 32'h0);
    send(32'(-ONE_Q), 32'h0);
    send(32'h0, 32'(ONE_Q));
    send(32'(ONE_Q + 5), 32'h0);
    drain();

    // no iterations allowed
    set_all(32'h0, 32'(ONE_Q), 16'd0, 5'd10, 32'd1678);
    pin_on = 1'b1;
    pin_val = mk(OC_UNDEC, 0, 1'b0);
    send(32'(ONE_Q / 2), 32'(ONE_Q / 2));
    pin_on = 1'b0;
    drain();

    // largest limit with points that leave at once; zero eps
    set_all(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 5'd31, 32'h0);
    send(32'h0, 32'h0);
    send(32'h0, 32'h1);
    drain();
    write_reg(CFG_EPS, 32'hFFFF_FFFF);
    send(32'h7FFF_FFFF, 32'h8000_0000);
    send(32'(ONE_Q), 32'(ONE_Q));
    drain();

    for (int ph = 0; ph < 16; ph++) begin
      logic [31:0] are, aim, ee;
      logic [15:0] mi;
      logic [4:0] mp;
      are = rand_coord();
      aim = rand_coord();
      if ($urandom_range(0, 3) == 0) begin
        are = 32'(longint'($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
        aim = 32'(longint'($urandom_range(0, 2 * ONE_Q)) - ONE_Q) >>> 2;
      end
      mp = (ph % 4 == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(2, 16));
      mi = (ph == 5) ? 16'd1 : 16'($urandom_range(mp < 2 ? 1 : mp, 24));
      case ($urandom_range(0, 5))
        0: ee = 32'($urandom_range(0, 3));
        1: ee = $urandom();
        2: ee = 32'(ONE_Q / 16);
        default: ee = $urandom_range(1, 20000);
      endcase
      drain();
      set_all(are, aim, mi, mp, ee);
      stall_quiet = (ph % 5 == 2);
      burst = 0;
      for (int n = 0; n < 95; n++) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 12);
          repeat ($urandom_range(0, 6)) @(negedge clk);
        end
        burst--;
        if ($urandom_range(0, 60) == 0) drain();
        send(rand_coord(), rand_coord());
      end
    end
    stall_quiet = 1'b0;

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #500_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/caje_pkg.sv
rtl/caje_ram.sv
rtl/caje_ctrl.sv
rtl/caje_dp.sv
rtl/cubic_antipodal_julia_escape.sv
dv/cubic_antipodal_julia_escape_tb.sv
